// ===== rtl/max_subset_sum_under_limit_assert.svh =====
// assertion macros for the max subset sum block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef MAX_SUBSET_SUM_UNDER_LIMIT_ASSERT_SVH
`define MAX_SUBSET_SUM_UNDER_LIMIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSS_ASSERT_IMP(label, ante, cons)
`define MSS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/mssul_pkg.sv =====
// shared types, sizes and helpers for the max subset sum block
// no dependencies
package mssul_pkg;

  localparam int MaxItems = 16;
  localparam int ValueW   = 32;
  localparam int SumW     = 36;
  localparam int IdxW     = $clog2(MaxItems);
  localparam int CntW     = $clog2(MaxItems + 1);

  typedef enum logic {
    StIdle,
    StSearch
  } state_e;

  // index of the lowest set bit, zero for an all-zero word
  function automatic logic [IdxW-1:0] lowest_set(input logic [MaxItems-1:0] w);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = MaxItems - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/max_subset_sum_under_limit.sv =====
// max subset sum under limit, top level
// depends on mssul_pkg and max_subset_sum_under_limit_assert.svh
`include "max_subset_sum_under_limit_assert.svh"

// Collects a set of unsigned values, one item per cycle while busy_o is low,
// and reports the largest subset sum that does not exceed target. A value
// above the target in force when it arrives is dropped; up to MaxItems (16)
// values are kept, and a further qualifying value sets the overflow flag.
// After the last item the block raises busy_o and walks all 2^n subsets of
// the n kept values in Gray code order: one shared 36-bit adder adds or
// removes a single value per cycle and one compare stage tracks the best
// sum; the result strobe result_valid_o comes in the cycle after the walk
// ends, for one cycle only, and the receiver must take it then since it
// cannot stall. busy_o is already low in that cycle, so the next set may
// start at once. The user must write the target register through target_we_i
// only while the block is idle; the block itself does not enforce this.
module max_subset_sum_under_limit
  import mssul_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // target register
  input  logic              target_we_i,
  input  logic [SumW-1:0]   target_i,
  // item in
  input  logic              start_i,
  output logic              busy_o,
  input  logic [ValueW-1:0] item_value_i,
  input  logic              last_item_i,
  // result out
  output logic              result_valid_o,
  output logic [SumW-1:0]   best_sum_o,
  output logic              overflow_o
);

  localparam logic [MaxItems-1:0] AllOnes = '1;

  state_e state_q, state_d;

  logic [SumW-1:0]     target_q;
  logic [ValueW-1:0]   store_q [MaxItems];
  logic [CntW-1:0]     kept_count_q;
  logic                overflow_seen_q;

  // subset walk
  logic [MaxItems-1:0] step_q;
  logic [MaxItems-1:0] mask_q;
  logic [SumW-1:0]     sum_q;
  logic [SumW-1:0]     best_q, best_d;

  logic                result_valid_q;
  logic                result_ovf_q;

  logic                accept;
  logic                keep_value;
  logic                store_full;
  logic [MaxItems-1:0] last_step;
  logic [MaxItems-1:0] step_next;
  logic [IdxW-1:0]     flip_idx;
  logic [SumW-1:0]     flip_val;
  logic [SumW-1:0]     sum_next;
  logic                walk_done;
  logic                hit;

  assign accept     = start_i && !busy_o;
  assign keep_value = {{(SumW-ValueW){1'b0}}, item_value_i} <= target_q;
  assign store_full = kept_count_q == CntW'(MaxItems);

  // final step of the walk has the low n bits set
  assign last_step = ~(AllOnes << kept_count_q);
  assign walk_done = step_q == last_step;

  // gray code: the bit that flips is the lowest set bit of the next step
  assign step_next = step_q + MaxItems'(1);
  assign flip_idx  = lowest_set(step_next);
  assign flip_val  = {{(SumW-ValueW){1'b0}}, store_q[flip_idx]};
  assign sum_next  = mask_q[flip_idx] ? sum_q - flip_val : sum_q + flip_val;

  // the current subset sum is judged from its register sum_q
  assign hit    = (sum_q <= target_q) && (sum_q > best_q);
  assign best_d = hit ? sum_q : best_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && last_item_i) begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (walk_done) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    busy_o = 1'b1;
    unique case (state_q)
      StIdle:   busy_o = 1'b0;
      StSearch: busy_o = 1'b1;
      default:  busy_o = 1'b1;
    endcase
  end

  assign result_valid_o = result_valid_q;
  assign best_sum_o     = best_q;
  assign overflow_o     = result_ovf_q;

  // value store, no reset
  always_ff @(posedge clk_i) begin
    if (accept && keep_value && !store_full) begin
      store_q[kept_count_q[IdxW-1:0]] <= item_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      target_q        <= '0;
      kept_count_q    <= '0;
      overflow_seen_q <= 1'b0;
      step_q          <= '0;
      mask_q          <= '0;
      sum_q           <= '0;
      best_q          <= '0;
      result_valid_q  <= 1'b0;
      result_ovf_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= 1'b0;
      if (target_we_i) begin
        target_q <= target_i;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (keep_value) begin
              if (store_full) begin
                overflow_seen_q <= 1'b1;
              end else begin
                kept_count_q <= kept_count_q + CntW'(1);
              end
            end
            if (last_item_i) begin
              // start the walk from the empty subset
              step_q <= '0;
              mask_q <= '0;
              sum_q  <= '0;
              best_q <= '0;
            end
          end
        end
        StSearch: begin
          best_q <= best_d;
          if (walk_done) begin
            result_valid_q  <= 1'b1;
            result_ovf_q    <= overflow_seen_q;
            overflow_seen_q <= 1'b0;
            kept_count_q    <= '0;
          end else begin
            step_q <= step_next;
            mask_q <= mask_q ^ (MaxItems'(1) << flip_idx);
            sum_q  <= sum_next;
          end
        end
        default: ;
      endcase
    end
  end

  `MSS_ASSERT_IMP(a_count_bound, 1'b1, kept_count_q <= CntW'(MaxItems))
  `MSS_ASSERT_IMP(a_mask_is_gray, state_q == StSearch, mask_q == (step_q ^ (step_q >> 1)))
  `MSS_ASSERT_NXT(a_done_strobes, state_q == StSearch && walk_done, result_valid_o && !busy_o)
  `MSS_ASSERT_NXT(a_strobe_single, result_valid_o, !result_valid_o)
  `MSS_ASSERT_NXT(a_clear_after_set, result_valid_o && !accept, kept_count_q == '0)

endmodule

// ===== tb/tb_max_subset_sum_under_limit.sv =====
// self-checking testbench for max_subset_sum_under_limit: directed sets, then random sets
// under several target settings and sender idle rates, with a scoreboard that predicts each sum
// depends on mssul_pkg and the max_subset_sum_under_limit rtl
module tb_max_subset_sum_under_limit;
  import mssul_pkg::*;

  // longest stretch with no item and no result; it must cover a full-store walk
  localparam int unsigned QuietLimit = 300000;

  // expected outcome of one set
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            ovf;
  } set_outcome_t;

  // tracks the set being collected and predicts the best sum when it closes
  class subset_scoreboard;
    logic [SumW-1:0]   limit;
    logic [ValueW-1:0] kept[$];
    bit                spilled;
    set_outcome_t      pending_q[$];
    int unsigned       mismatches;

    function new();
      limit      = '0;
      spilled    = 1'b0;
      mismatches = 0;
    endfunction

    function void set_limit(input logic [SumW-1:0] t);
      limit = t;
    endfunction

    function void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: %s", msg);
      end
    endfunction

    // plain search over every subset of the kept values
    function automatic logic [SumW-1:0] best_fit();
      logic [SumW-1:0] best;
      logic [SumW-1:0] acc;
      int              n;
      n    = kept.size();
      best = '0;
      for (int m = 0; m < (1 << n); m++) begin
        acc = '0;
        for (int i = 0; i < n; i++) begin
          if (m[i]) begin
            acc += SumW'(kept[i]);
          end
        end
        if (acc <= limit && acc > best) begin
          best = acc;
        end
      end
      return best;
    endfunction

    // accepted input item
    function void note_item(input logic [ValueW-1:0] v, input logic last);
      set_outcome_t want;
      if (SumW'(v) <= limit) begin
        if (kept.size() < MaxItems) begin
          kept = {kept, v};
        end else begin
          spilled = 1'b1;
        end
      end
      if (last) begin
        want.sum  = best_fit();
        want.ovf  = spilled;
        pending_q = {pending_q, want};
        kept.delete();
        spilled = 1'b0;
      end
    endfunction

    // accepted result, compared with the oldest expectation
    function void check_result(input logic [SumW-1:0] sum, input logic ovf);
      set_outcome_t want;
      if (pending_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result best_sum=%0d overflow=%0b", sum, ovf));
        return;
      end
      want = pending_q.pop_front();
      if (sum !== want.sum) begin
        note_mismatch($sformatf("best_sum expected %0d got %0d", want.sum, sum));
      end
      if (ovf !== want.ovf) begin
        note_mismatch($sformatf("overflow expected %0b got %0b", want.ovf, ovf));
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              target_we_i;
  logic [SumW-1:0]   target_i;
  logic              start_i;
  logic              busy_o;
  logic [ValueW-1:0] item_value_i;
  logic              last_item_i;
  logic              result_valid_o;
  logic [SumW-1:0]   best_sum_o;
  logic              overflow_o;

  subset_scoreboard sb = new();
  int unsigned      quiet_cycles = 0;
  int unsigned      sender_idle_pct = 0;
  int unsigned      set_no = 0;

  always #1 clk_i = ~clk_i;

  max_subset_sum_under_limit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .target_we_i    (target_we_i),
    .target_i       (target_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_value_i   (item_value_i),
    .last_item_i    (last_item_i),
    .result_valid_o (result_valid_o),
    .best_sum_o     (best_sum_o),
    .overflow_o     (overflow_o)
  );

  // monitor: sees pre-edge values, so results go before items taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        sb.check_result(best_sum_o, overflow_o);
      end
      if (start_i && !busy_o) begin
        sb.note_item(item_value_i, last_item_i);
      end
      // watchdog on cycles with no item and no result
      if (result_valid_o || (start_i && !busy_o)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("tb_max_subset_sum_under_limit NOT OK");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // one item: optional idle cycles first, then hold start until busy is low at an edge
  // start is left high so back-to-back items need no extra assignment
  task automatic send_item(input logic [ValueW-1:0] v, input logic last);
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    item_value_i <= v;
    last_item_i  <= last;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
  endtask

  // sender pauses until every expected sum has come back
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // target write; start is low so no item can slip in on the write edge
  task automatic write_target(input logic [SumW-1:0] t);
    start_i     <= 1'b0;
    target_we_i <= 1'b1;
    target_i    <= t;
    @(posedge clk_i);
    target_we_i <= 1'b0;
    sb.set_limit(t);
  endtask

  // value mix: most fit under the target, some are noise that gets dropped
  // with fit set only values at or under the target are drawn
  function automatic logic [ValueW-1:0] pick_value(input logic [SumW-1:0] t, input bit fit);
    logic [63:0] cap;
    logic [63:0] r;
    int unsigned sel;
    cap = (t > 36'h0_FFFF_FFFF) ? 64'hFFFF_FFFF : 64'(t);
    r   = {$urandom, $urandom};
    sel = fit ? $urandom_range(74, 0) : $urandom_range(99, 0);
    if (sel < 50) begin
      return ValueW'(r % (cap + 1));
    end
    if (sel < 75) begin
      // smaller values make many subsets compete for the target
      return ValueW'(r % (cap / 3 + 1));
    end
    if (sel < 90) begin
      return $urandom;
    end
    case ($urandom_range(3, 0))
      0: return '0;
      1: return ValueW'(cap);
      2: return ValueW'(cap + 1);
      default: return '1;
    endcase
  endfunction

  // random sets under one target until about n_items items have gone in
  task automatic run_phase(input logic [SumW-1:0] t, input int unsigned idle_pct,
                           input int unsigned n_items);
    int unsigned sent;
    int unsigned set_len;
    bit          full_set;
    wait_drained();
    write_target(t);
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      set_no++;
      // a rare set that fills the store and spills over
      full_set = (set_no % 70 == 35);
      if (full_set) begin
        set_len = $urandom_range(20, 17);
      end else if ($urandom_range(9, 0) < 2) begin
        set_len = $urandom_range(12, 9);
      end else begin
        set_len = $urandom_range(8, 1);
      end
      for (int k = 0; k < set_len; k++) begin
        send_item(pick_value(t, full_set), k == set_len - 1);
      end
      sent += set_len;
      // now and then the sender holds off until the block has answered
      if ($urandom_range(49, 0) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    target_we_i  = 1'b0;
    target_i     = '0;
    start_i      = 1'b0;
    item_value_i = '0;
    last_item_i  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty set: the reset target is zero and the only value is dropped
    send_item(32'd5, 1'b1);
    wait_drained();

    // value equal to the target is kept, one above it dropped
    write_target(36'd100);
    send_item(32'd101, 1'b0);
    send_item(32'd100, 1'b0);
    send_item(32'd60, 1'b1);
    wait_drained();

    // target raised in the middle of a set: 150 only fits the new target
    send_item(32'd90, 1'b0);
    write_target(36'd200);
    send_item(32'd150, 1'b0);
    send_item(32'd40, 1'b1);
    wait_drained();

    // widest target, 17 qualifying values: store full plus overflow, largest sums
    write_target('1);
    for (int k = 0; k < 17; k++) begin
      case (k % 4)
        0: send_item('1, k == 16);
        1: send_item(32'hAAAA_AAAA, k == 16);
        2: send_item(32'h5555_5555, k == 16);
        default: send_item(k == 3 ? 32'h0 : 32'hFFFF_FFFE, k == 16);
      endcase
    end

    // random part: target extremes and in between, sender idle rates of 0, 74 and 9
    run_phase('1, 0, 210);
    run_phase({4'($urandom_range(15, 0)), $urandom}, 74, 210);
    run_phase(36'd1000, 0, 210);
    run_phase(36'h0_FFFF_FFFF, 9, 210);
    run_phase(36'($urandom_range(32'h0010_0000, 1)), 74, 210);
    run_phase('0, 9, 210);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb_max_subset_sum_under_limit OK");
    end else begin
      $display("tb_max_subset_sum_under_limit NOT OK");
    end
    $finish;
  end

endmodule
